// ===== src/v3au_pkg.sv =====
// Shared constants and opcode type for the three-component vector ALU.
`default_nettype none

package v3au_pkg;

    localparam int DATA_WIDTH = 32;
    localparam int FRAC_BITS  = 16;
    localparam int OP_WIDTH   = 4;

    typedef enum logic [OP_WIDTH-1:0] {
        OP_ADD   = 4'd0,
        OP_SUB   = 4'd1,
        OP_MUL   = 4'd2,
        OP_DIV   = 4'd3,
        OP_ADDS  = 4'd4,
        OP_SUBS  = 4'd5,
        OP_MULS  = 4'd6,
        OP_DIVS  = 4'd7,
        OP_SSUB  = 4'd8,
        OP_SDIV  = 4'd9,
        OP_NEG   = 4'd10,
        OP_NORM  = 4'd11,
        OP_UNIT  = 4'd12,
        OP_CROSS = 4'd13,
        OP_DOT   = 4'd14
    } t_op;

endpackage

`default_nettype wire

// ===== src/v3au_in_if.sv =====
// Command channel: opcode, two vectors and a scalar.
`default_nettype none

interface v3au_in_if #(
    parameter int DATA_WIDTH = v3au_pkg::DATA_WIDTH
);
    logic                               valid;
    logic                               ready;
    logic [v3au_pkg::OP_WIDTH-1:0]      op;
    logic signed [DATA_WIDTH-1:0]       ax;
    logic signed [DATA_WIDTH-1:0]       ay;
    logic signed [DATA_WIDTH-1:0]       az;
    logic signed [DATA_WIDTH-1:0]       bx;
    logic signed [DATA_WIDTH-1:0]       by;
    logic signed [DATA_WIDTH-1:0]       bz;
    logic signed [DATA_WIDTH-1:0]       scalar_in;

    modport source (output valid, op, ax, ay, az, bx, by, bz, scalar_in, input ready);
    modport sink   (input valid, op, ax, ay, az, bx, by, bz, scalar_in, output ready);
endinterface

`default_nettype wire

// ===== src/v3au_out_if.sv =====
// Result channel: vector result, scalar result and flags.
`default_nettype none

interface v3au_out_if #(
    parameter int DATA_WIDTH = v3au_pkg::DATA_WIDTH
);
    logic                               valid;
    logic                               ready;
    logic signed [DATA_WIDTH-1:0]       rx;
    logic signed [DATA_WIDTH-1:0]       ry;
    logic signed [DATA_WIDTH-1:0]       rz;
    logic signed [DATA_WIDTH-1:0]       scalar_out;
    logic                               div_zero;
    logic                               saturated;

    modport source (output valid, rx, ry, rz, scalar_out, div_zero, saturated, input ready);
    modport sink   (input valid, rx, ry, rz, scalar_out, div_zero, saturated, output ready);
endinterface

`default_nettype wire

// ===== src/v3au_mul_lane.sv =====
// One component lane: registered products and saturated add-type result.
`default_nettype none

module v3au_mul_lane #(
    parameter int DATA_WIDTH = v3au_pkg::DATA_WIDTH
) (
    input  logic                          i_clk,
    input  logic                          i_en,
    input  v3au_pkg::t_op                 i_op,
    input  logic signed [DATA_WIDTH-1:0]  i_a,
    input  logic signed [DATA_WIDTH-1:0]  i_b,
    input  logic signed [DATA_WIDTH-1:0]  i_s,
    input  logic signed [DATA_WIDTH-1:0]  i_aj,
    input  logic signed [DATA_WIDTH-1:0]  i_bk,
    input  logic signed [DATA_WIDTH-1:0]  i_ak,
    input  logic signed [DATA_WIDTH-1:0]  i_bj,
    output logic signed [2*DATA_WIDTH-1:0] o_ab,
    output logic signed [2*DATA_WIDTH-1:0] o_as,
    output logic signed [2*DATA_WIDTH-1:0] o_aa,
    output logic signed [2*DATA_WIDTH-1:0] o_c1,
    output logic signed [2*DATA_WIDTH-1:0] o_c2,
    output logic [DATA_WIDTH-1:0]         o_lin,
    output logic                          o_lin_sat
);
    localparam int W  = DATA_WIDTH;
    localparam int W1 = W + 1;
    localparam logic [W-1:0] MIN = {1'b1, {(W-1){1'b0}}};
    localparam logic [W-1:0] MAX = {1'b0, {(W-1){1'b1}}};

    logic signed [W1-1:0] sum;
    logic [W-1:0]         n_lin;
    logic                 n_lin_sat;

    always_comb begin
        case (i_op)
            v3au_pkg::OP_ADD:  sum = W1'(i_a) + W1'(i_b);
            v3au_pkg::OP_SUB:  sum = W1'(i_a) - W1'(i_b);
            v3au_pkg::OP_ADDS: sum = W1'(i_a) + W1'(i_s);
            v3au_pkg::OP_SUBS: sum = W1'(i_a) - W1'(i_s);
            v3au_pkg::OP_SSUB: sum = W1'(i_s) - W1'(i_a);
            v3au_pkg::OP_NEG:  sum = W1'(0) - W1'(i_a);
            default:           sum = '0;
        endcase
        n_lin_sat = sum[W] != sum[W-1];
        n_lin     = n_lin_sat ? (sum[W] ? MIN : MAX) : sum[W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_ab      <= i_a * i_b;
            o_as      <= i_a * i_s;
            o_aa      <= i_a * i_a;
            o_c1      <= i_aj * i_bk;
            o_c2      <= i_ak * i_bj;
            o_lin     <= n_lin;
            o_lin_sat <= n_lin_sat;
        end
    end

endmodule

`default_nettype wire

// ===== src/v3au_sqrt.sv =====
// Pipelined integer square root, one result bit per stage.
`default_nettype none

module v3au_sqrt #(
    parameter int DATA_WIDTH = v3au_pkg::DATA_WIDTH,
    parameter int SIDE_W     = 1
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_en,
    input  logic [2*DATA_WIDTH-1:0]   i_rad,
    input  logic [SIDE_W-1:0]         i_side,
    output logic [DATA_WIDTH-1:0]     o_root,
    output logic [SIDE_W-1:0]         o_side
);
    localparam int W  = DATA_WIDTH;
    localparam int RW = W + 3;

    logic [RW-1:0]     r_rem  [0:W];
    logic [W-1:0]      r_res  [0:W];
    logic [2*W-1:0]    r_rad  [0:W];
    logic [SIDE_W-1:0] r_side [0:W];

    logic [RW-1:0]     n_rem  [1:W];
    logic [W-1:0]      n_res  [1:W];
    logic [2*W-1:0]    n_rad  [1:W];

    always_comb begin
        logic [RW-1:0] shf;
        logic [RW-1:0] trial;
        logic          ge;
        for (int k = 1; k <= W; k++) begin
            // bring down the next two radicand bits
            shf      = {r_rem[k-1][W:0], r_rad[k-1][2*W-1 -: 2]};
            trial    = {1'b0, r_res[k-1], 2'b01};
            ge       = shf >= trial;
            n_rem[k] = ge ? shf - trial : shf;
            n_res[k] = {r_res[k-1][W-2:0], ge};
            n_rad[k] = {r_rad[k-1][2*W-3:0], 2'b00};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= W; k++) begin
                r_rem[k]  <= '0;
                r_res[k]  <= '0;
                r_rad[k]  <= '0;
                r_side[k] <= '0;
            end
        end else if (i_en) begin
            r_rem[0]  <= '0;
            r_res[0]  <= '0;
            r_rad[0]  <= i_rad;
            r_side[0] <= i_side;
            for (int k = 1; k <= W; k++) begin
                r_rem[k]  <= n_rem[k];
                r_res[k]  <= n_res[k];
                r_rad[k]  <= n_rad[k];
                r_side[k] <= r_side[k-1];
            end
        end
    end

    assign o_root = r_res[W];
    assign o_side = r_side[W];

`ifndef SYNTH
    // remainder of a floor square root never exceeds twice the root
    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rem[W] <= RW'({r_res[W], 1'b0}))
        else $error("sqrt remainder out of range");
`endif

endmodule

`default_nettype wire

// ===== src/v3au_div.sv =====
// Pipelined restoring divider, one quotient bit per stage.
`default_nettype none

module v3au_div #(
    parameter int DATA_WIDTH = v3au_pkg::DATA_WIDTH,
    parameter int FRAC_BITS  = v3au_pkg::FRAC_BITS,
    parameter int SIDE_W     = 1
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_en,
    input  logic [DATA_WIDTH+FRAC_BITS-1:0]  i_num,
    input  logic [DATA_WIDTH-1:0]            i_den,
    input  logic [SIDE_W-1:0]                i_side,
    output logic [DATA_WIDTH+FRAC_BITS-1:0]  o_quo,
    output logic [SIDE_W-1:0]                o_side
);
    localparam int W = DATA_WIDTH;
    localparam int S = DATA_WIDTH + FRAC_BITS;

    logic [W-1:0]      r_a    [0:S];
    logic [S-1:0]      r_q    [0:S];
    logic [W-1:0]      r_d    [0:S];
    logic [SIDE_W-1:0] r_side [0:S];

    logic [W-1:0]      n_a    [1:S];
    logic [S-1:0]      n_q    [1:S];

    always_comb begin
        logic [W:0] t;
        logic [W:0] dd;
        logic [W:0] df;
        logic       ge;
        for (int k = 1; k <= S; k++) begin
            t      = {r_a[k-1], r_q[k-1][S-1]};
            dd     = {1'b0, r_d[k-1]};
            ge     = t >= dd;
            df     = t - dd;
            n_a[k] = ge ? df[W-1:0] : t[W-1:0];
            n_q[k] = {r_q[k-1][S-2:0], ge};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= S; k++) begin
                r_a[k]    <= '0;
                r_q[k]    <= '0;
                r_d[k]    <= '0;
                r_side[k] <= '0;
            end
        end else if (i_en) begin
            r_a[0]    <= '0;
            r_q[0]    <= i_num;
            r_d[0]    <= i_den;
            r_side[0] <= i_side;
            for (int k = 1; k <= S; k++) begin
                r_a[k]    <= n_a[k];
                r_q[k]    <= n_q[k];
                r_d[k]    <= r_d[k-1];
                r_side[k] <= r_side[k-1];
            end
        end
    end

    assign o_quo  = r_q[S];
    assign o_side = r_side[S];

`ifndef SYNTH
    a_rem_lt_den: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_d[S] != '0) |-> (r_a[S] < r_d[S]))
        else $error("divider remainder not below divisor");
`endif

endmodule

`default_nettype wire

// ===== src/vector3_arithmetic_unit.sv =====
// Top level of the three-component fixed-point vector ALU.
`default_nettype none

// Fully pipelined: one transaction is accepted per cycle unless the sink holds
// the result register, when the whole pipeline holds with it. Each passes input
// capture, the multiplier and merge registers, the square-root pipeline
// (DATA_WIDTH+1 stages, a root bit in each after the first), the three divider
// lanes (DATA_WIDTH+FRAC_BITS+1 stages, a quotient bit in each after the first)
// and the output register; every opcode takes the same path. Results (Q16.16 by
// default) are truncated toward zero and saturated to the signed word range.

module vector3_arithmetic_unit #(
    parameter int DATA_WIDTH = v3au_pkg::DATA_WIDTH,
    parameter int FRAC_BITS  = v3au_pkg::FRAC_BITS
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    v3au_in_if.sink       i_cmd,
    v3au_out_if.source    o_res
);
    localparam int W    = DATA_WIDTH;
    localparam int F    = FRAC_BITS;
    localparam int W2   = 2 * W;
    localparam int W2P1 = W2 + 1;
    localparam int W2P2 = W2 + 2;
    localparam int S    = W + F;
    localparam logic [W-1:0] MIN = {1'b1, {(W-1){1'b0}}};
    localparam logic [W-1:0] MAX = {1'b0, {(W-1){1'b1}}};
    localparam logic signed [W2P1-1:0] RND1 = W2P1'((1 << F) - 1);
    localparam logic signed [W2P2-1:0] RND2 = W2P2'((1 << F) - 1);

    typedef struct packed {
        logic                vld;
        v3au_pkg::t_op       op;
        logic [2:0][W-1:0]   a;
        logic [2:0][W-1:0]   b;
        logic [W-1:0]        s;
        logic [2:0][W-1:0]   val;
        logic [2:0]          vsat;
        logic [W-1:0]        sc;
        logic                sc_sat;
    } t_sq_side;

    typedef struct packed {
        logic          use_div;
        logic          neg;
        logic [W-1:0]  val;
        logic          sat;
        logic          dz;
    } t_dv_side;

    typedef struct packed {
        logic          vld;
        logic [W-1:0]  sc;
        logic          sc_sat;
    } t_head;

    logic en;
    logic r_out_vld;

    assign en          = !r_out_vld || o_res.ready;
    assign i_cmd.ready = en;

    // ---- stage 0: input capture
    logic                 r0_vld;
    v3au_pkg::t_op        r0_op;
    logic signed [W-1:0]  r0_a [3];
    logic signed [W-1:0]  r0_b [3];
    logic signed [W-1:0]  r0_s;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_vld <= 1'b0;
        end else if (en) begin
            r0_vld <= i_cmd.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r0_op   <= v3au_pkg::t_op'(i_cmd.op);
            r0_a[0] <= i_cmd.ax;
            r0_a[1] <= i_cmd.ay;
            r0_a[2] <= i_cmd.az;
            r0_b[0] <= i_cmd.bx;
            r0_b[1] <= i_cmd.by;
            r0_b[2] <= i_cmd.bz;
            r0_s    <= i_cmd.scalar_in;
        end
    end

    // ---- stage 1: multiplier lanes
    logic signed [W2-1:0] w_ab [3];
    logic signed [W2-1:0] w_as [3];
    logic signed [W2-1:0] w_aa [3];
    logic signed [W2-1:0] w_c1 [3];
    logic signed [W2-1:0] w_c2 [3];
    logic [W-1:0]         w_lin [3];
    logic                 w_lsat [3];

    for (genvar i = 0; i < 3; i++) begin : g_lane
        v3au_mul_lane #(.DATA_WIDTH(W)) u_lane (
            .i_clk     (i_clk),
            .i_en      (en),
            .i_op      (r0_op),
            .i_a       (r0_a[i]),
            .i_b       (r0_b[i]),
            .i_s       (r0_s),
            .i_aj      (r0_a[(i+1)%3]),
            .i_bk      (r0_b[(i+2)%3]),
            .i_ak      (r0_a[(i+2)%3]),
            .i_bj      (r0_b[(i+1)%3]),
            .o_ab      (w_ab[i]),
            .o_as      (w_as[i]),
            .o_aa      (w_aa[i]),
            .o_c1      (w_c1[i]),
            .o_c2      (w_c2[i]),
            .o_lin     (w_lin[i]),
            .o_lin_sat (w_lsat[i])
        );
    end

    logic                 r1_vld;
    v3au_pkg::t_op        r1_op;
    logic signed [W-1:0]  r1_a [3];
    logic signed [W-1:0]  r1_b [3];
    logic signed [W-1:0]  r1_s;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
        end else if (en) begin
            r1_vld <= r0_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_op <= r0_op;
            r1_a  <= r0_a;
            r1_b  <= r0_b;
            r1_s  <= r0_s;
        end
    end

    // ---- stage 2: merge products into sums and differences
    logic signed [W2P1-1:0] n2_trm [3];
    logic [W2-1:0]          n2_sq;
    logic signed [W2P2-1:0] n2_dot;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            case (r1_op)
                v3au_pkg::OP_CROSS: n2_trm[i] = W2P1'(w_c1[i]) - W2P1'(w_c2[i]);
                v3au_pkg::OP_MULS:  n2_trm[i] = W2P1'(w_as[i]);
                default:            n2_trm[i] = W2P1'(w_ab[i]);
            endcase
        end
        n2_sq  = $unsigned(w_aa[0]) + $unsigned(w_aa[1]) + $unsigned(w_aa[2]);
        n2_dot = W2P2'(w_ab[0]) + W2P2'(w_ab[1]) + W2P2'(w_ab[2]);
    end

    logic                   r2_vld;
    v3au_pkg::t_op          r2_op;
    logic signed [W-1:0]    r2_a [3];
    logic signed [W-1:0]    r2_b [3];
    logic signed [W-1:0]    r2_s;
    logic signed [W2P1-1:0] r2_trm [3];
    logic [W-1:0]           r2_lin [3];
    logic                   r2_lsat [3];
    logic [W2-1:0]          r2_sq;
    logic signed [W2P2-1:0] r2_dot;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_vld <= 1'b0;
        end else if (en) begin
            r2_vld <= r1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r2_op   <= r1_op;
            r2_a    <= r1_a;
            r2_b    <= r1_b;
            r2_s    <= r1_s;
            r2_trm  <= n2_trm;
            r2_lin  <= w_lin;
            r2_lsat <= w_lsat;
            r2_sq   <= n2_sq;
            r2_dot  <= n2_dot;
        end
    end

    // truncate toward zero, saturate, pick each lane's non-divide result
    t_sq_side sq_in;

    always_comb begin
        logic signed [W2P1-1:0] adj;
        logic signed [W2P1-1:0] sh;
        logic signed [W2P2-1:0] dadj;
        logic signed [W2P2-1:0] dsh;
        logic                   tfit;
        logic                   dfit;
        logic [W-1:0]           tval;
        sq_in     = '0;
        sq_in.vld = r2_vld;
        sq_in.op  = r2_op;
        sq_in.s   = r2_s;
        for (int i = 0; i < 3; i++) begin
            sq_in.a[i] = r2_a[i];
            sq_in.b[i] = r2_b[i];
            adj  = r2_trm[i] + (r2_trm[i][W2] ? RND1 : W2P1'(0));
            sh   = adj >>> F;
            tfit = (sh[W2:W-1] == '0) || (sh[W2:W-1] == '1);
            tval = tfit ? sh[W-1:0] : (sh[W2] ? MIN : MAX);
            if (r2_op inside {v3au_pkg::OP_MUL, v3au_pkg::OP_MULS, v3au_pkg::OP_CROSS}) begin
                sq_in.val[i]  = tval;
                sq_in.vsat[i] = !tfit;
            end else if (r2_op inside {v3au_pkg::OP_ADD, v3au_pkg::OP_SUB, v3au_pkg::OP_ADDS,
                                       v3au_pkg::OP_SUBS, v3au_pkg::OP_SSUB,
                                       v3au_pkg::OP_NEG}) begin
                sq_in.val[i]  = r2_lin[i];
                sq_in.vsat[i] = r2_lsat[i];
            end
        end
        dadj = r2_dot + (r2_dot[W2P2-1] ? RND2 : W2P2'(0));
        dsh  = dadj >>> F;
        dfit = (dsh[W2P2-1:W-1] == '0) || (dsh[W2P2-1:W-1] == '1);
        if (r2_op == v3au_pkg::OP_DOT) begin
            sq_in.sc     = dfit ? dsh[W-1:0] : (dsh[W2P2-1] ? MIN : MAX);
            sq_in.sc_sat = !dfit;
        end
    end

    // ---- square root of the sum of squares
    logic [W-1:0] mag;
    t_sq_side     sq_out;

    v3au_sqrt #(.DATA_WIDTH(W), .SIDE_W($bits(t_sq_side))) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_rad   (r2_sq),
        .i_side  (sq_in),
        .o_root  (mag),
        .o_side  (sq_out)
    );

    // ---- divider operand setup
    logic [S-1:0] div_num [3];
    logic [W-1:0] div_den [3];
    t_dv_side     dv_in [3];
    t_head        hd_in;

    always_comb begin
        logic signed [W-1:0] nw;
        logic signed [W-1:0] dw;
        logic [W-1:0]        nmag;
        logic [W-1:0]        dmag;
        logic                nneg;
        logic                dneg;
        logic                is_div;
        is_div = sq_out.op inside {v3au_pkg::OP_DIV, v3au_pkg::OP_DIVS,
                                   v3au_pkg::OP_SDIV, v3au_pkg::OP_UNIT};
        for (int i = 0; i < 3; i++) begin
            case (sq_out.op)
                v3au_pkg::OP_DIV: begin
                    nw = sq_out.a[i];
                    dw = sq_out.b[i];
                end
                v3au_pkg::OP_DIVS: begin
                    nw = sq_out.a[i];
                    dw = sq_out.s;
                end
                v3au_pkg::OP_SDIV: begin
                    nw = sq_out.s;
                    dw = sq_out.a[i];
                end
                default: begin
                    nw = sq_out.a[i];
                    dw = '0;
                end
            endcase
            nneg = nw[W-1];
            nmag = nneg ? W'(0) - nw : nw;
            if (sq_out.op == v3au_pkg::OP_UNIT) begin
                dneg = 1'b0;
                dmag = mag;
            end else begin
                dneg = dw[W-1];
                dmag = dneg ? W'(0) - dw : dw;
            end
            div_num[i]       = {nmag, {F{1'b0}}};
            div_den[i]       = dmag;
            dv_in[i].use_div = 1'b0;
            dv_in[i].neg     = 1'b0;
            dv_in[i].val     = sq_out.val[i];
            dv_in[i].sat     = sq_out.vsat[i];
            dv_in[i].dz      = 1'b0;
            if (is_div) begin
                dv_in[i].sat = 1'b0;
                if (dmag == '0) begin
                    // unit of a zero vector returns it unchanged, i.e. zero
                    if (sq_out.op == v3au_pkg::OP_UNIT) begin
                        dv_in[i].val = '0;
                    end else begin
                        dv_in[i].dz  = 1'b1;
                        dv_in[i].val = (nmag == '0) ? '0 : (nneg ? MIN : MAX);
                    end
                end else begin
                    dv_in[i].use_div = 1'b1;
                    dv_in[i].neg     = nneg ^ dneg;
                    dv_in[i].val     = '0;
                end
            end
        end
        hd_in.vld = sq_out.vld;
        if (sq_out.op == v3au_pkg::OP_NORM) begin
            hd_in.sc     = mag[W-1] ? MAX : mag;
            hd_in.sc_sat = mag[W-1];
        end else begin
            hd_in.sc     = sq_out.sc;
            hd_in.sc_sat = sq_out.sc_sat;
        end
    end

    // ---- divider lanes and the matching scalar delay line
    logic [S-1:0] quo [3];
    t_dv_side     dv_out [3];

    for (genvar i = 0; i < 3; i++) begin : g_div
        v3au_div #(.DATA_WIDTH(W), .FRAC_BITS(F), .SIDE_W($bits(t_dv_side))) u_div (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_num   (div_num[i]),
            .i_den   (div_den[i]),
            .i_side  (dv_in[i]),
            .o_quo   (quo[i]),
            .o_side  (dv_out[i])
        );
    end

    t_head r_hd [0:S];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= S; k++) begin
                r_hd[k] <= '0;
            end
        end else if (en) begin
            r_hd[0] <= hd_in;
            for (int k = 1; k <= S; k++) begin
                r_hd[k] <= r_hd[k-1];
            end
        end
    end

    // ---- final saturation and output register
    logic [W-1:0] n_val [3];
    logic [2:0]   n_sat;
    logic [2:0]   n_dz;

    always_comb begin
        logic ovf;
        for (int i = 0; i < 3; i++) begin
            ovf     = 1'b0;
            n_dz[i] = dv_out[i].dz;
            if (dv_out[i].use_div) begin
                if (dv_out[i].neg) begin
                    ovf      = (|quo[i][S-1:W]) || (quo[i][W-1] && (|quo[i][W-2:0]));
                    n_val[i] = ovf ? MIN : W'(0) - quo[i][W-1:0];
                end else begin
                    ovf      = |quo[i][S-1:W-1];
                    n_val[i] = ovf ? MAX : quo[i][W-1:0];
                end
                n_sat[i] = ovf;
            end else begin
                n_val[i] = dv_out[i].val;
                n_sat[i] = dv_out[i].sat;
            end
        end
    end

    logic [W-1:0] r_out_rx;
    logic [W-1:0] r_out_ry;
    logic [W-1:0] r_out_rz;
    logic [W-1:0] r_out_sc;
    logic         r_out_dz;
    logic         r_out_sat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (en) begin
            r_out_vld <= r_hd[S].vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out_rx  <= n_val[0];
            r_out_ry  <= n_val[1];
            r_out_rz  <= n_val[2];
            r_out_sc  <= r_hd[S].sc;
            r_out_dz  <= |n_dz;
            r_out_sat <= (|n_sat) | r_hd[S].sc_sat;
        end
    end

    assign o_res.valid      = r_out_vld;
    assign o_res.rx         = r_out_rx;
    assign o_res.ry         = r_out_ry;
    assign o_res.rz         = r_out_rz;
    assign o_res.scalar_out = r_out_sc;
    assign o_res.div_zero   = r_out_dz;
    assign o_res.saturated  = r_out_sat;

`ifndef SYNTH
    a_rst_empty: assert property (@(posedge i_clk) !i_rst_n |=> !o_res.valid)
        else $error("result valid after reset");
`endif

endmodule

`default_nettype wire
